// ===== design/lpi_pkg.sv =====
// Shared types and constants for the two-line intersection core.
// Used by the front end, the divider cells, the back end, the top level and the checker.
package lpi_pkg;

  // Quotient bits produced by the divider chain, one per cell.
  localparam int DIV_BITS = 48;
  // Width of the partial remainder and of the divisor magnitude.
  localparam int REM_W    = 32;
  // Cycles from an accepted request to its result strobe.
  localparam int LATENCY  = DIV_BITS + 6;

  localparam logic [14:0]         THR_RESET = 15'd1638;
  localparam logic [DIV_BITS-1:0] T_LIMIT   = {1'b1, {(DIV_BITS-1){1'b0}}};

  // Data that rides along with the division unchanged.
  typedef struct packed {
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [15:0] ux;
    logic signed [15:0] uy;
    logic               t_neg;
    logic               ovf;
    logic               found;
    logic               crossing;
  } lpi_side_t;

  // One slot of the divider chain.
  typedef struct packed {
    logic                valid;
    logic [REM_W-1:0]    rem;
    logic [DIV_BITS-1:0] work;
    logic [REM_W-1:0]    dvs;
    lpi_side_t           side;
  } lpi_cell_t;

endpackage

// ===== design/line_pair_intersection_core.sv =====
// Top level of the two-line intersection core: threshold register, front end,
// divider cell chain and back end. Depends on lpi_pkg, lpi_front, lpi_div_cell, lpi_back.
//
//   channel   handshake          payload
//   request   start / busy       in_first_*, in_second_* (points Q16.16, directions Q1.14)
//   result    out_valid strobe   out_found, out_inter_x, out_inter_y, out_clipped, out_crossing
//   config    cfg_we             cfg_wdata (cross threshold, Q1.14)
//
// One request is taken every cycle while busy is low; each result travels from its
// request through the 48-cell restoring divider chain plus six arithmetic stages.
// Reset loads the threshold with 1638 and empties the pipeline; busy is high
// during reset and for the cycle after it, and low at all other times.
// Results are shown for one cycle only; the receiver cannot stall them.
module line_pair_intersection_core
  import lpi_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_first_point_x,
  input  logic signed [31:0] in_first_point_y,
  input  logic signed [15:0] in_first_dir_x,
  input  logic signed [15:0] in_first_dir_y,
  input  logic signed [31:0] in_second_point_x,
  input  logic signed [31:0] in_second_point_y,
  input  logic signed [15:0] in_second_dir_x,
  input  logic signed [15:0] in_second_dir_y,
  input  logic               cfg_we,
  input  logic [14:0]        cfg_wdata,
  output logic               out_valid,
  output logic               out_found,
  output logic signed [31:0] out_inter_x,
  output logic signed [31:0] out_inter_y,
  output logic               out_clipped,
  output logic               out_crossing
);

  logic        busy_r;
  logic [14:0] thr_r;
  logic        acc;
  lpi_cell_t   chain [0:DIV_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      thr_r  <= THR_RESET;
    end else begin
      busy_r <= 1'b0;
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
    end
  end

  assign busy = busy_r;
  assign acc  = start && !busy_r;

  lpi_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .acc    (acc),
    .ax     (in_first_point_x),
    .ay     (in_first_point_y),
    .ux     (in_first_dir_x),
    .uy     (in_first_dir_y),
    .bx     (in_second_point_x),
    .by     (in_second_point_y),
    .vx     (in_second_dir_x),
    .vy     (in_second_dir_y),
    .thr    (thr_r),
    .cell_o (chain[0])
  );

  for (genvar i = 0; i < DIV_BITS; i++) begin : g_cell
    lpi_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .cell_i (chain[i]),
      .cell_o (chain[i+1])
    );
  end

  lpi_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cell_i       (chain[DIV_BITS]),
    .out_valid    (out_valid),
    .out_found    (out_found),
    .out_inter_x  (out_inter_x),
    .out_inter_y  (out_inter_y),
    .out_clipped  (out_clipped),
    .out_crossing (out_crossing)
  );

endmodule

// ===== design/lpi_front.sv =====
// Front end: determinant, dot product, numerator and divider setup in three stages.
// Depends on lpi_pkg; feeds the first cell of the divider chain.
module lpi_front
  import lpi_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc,
  input  logic signed [31:0] ax,
  input  logic signed [31:0] ay,
  input  logic signed [15:0] ux,
  input  logic signed [15:0] uy,
  input  logic signed [31:0] bx,
  input  logic signed [31:0] by,
  input  logic signed [15:0] vx,
  input  logic signed [15:0] vy,
  input  logic [14:0]        thr,
  output lpi_cell_t          cell_o
);

  // Stage 1: products of the directions and point difference.
  logic signed [31:0] p_det_a, p_det_b, p_dot_a, p_dot_b;
  logic signed [32:0] det_nxt, dot_nxt, dcx_nxt, dcy_nxt;

  logic               s1_valid_r;
  logic signed [32:0] s1_det_r, s1_dot_r, s1_dcx_r, s1_dcy_r;
  logic signed [31:0] s1_ax_r, s1_ay_r;
  logic signed [15:0] s1_ux_r, s1_uy_r, s1_vx_r, s1_vy_r;

  assign p_det_a = ux * vy;
  assign p_det_b = uy * vx;
  assign p_dot_a = ux * vx;
  assign p_dot_b = uy * vy;
  assign det_nxt = 33'(p_det_a) - 33'(p_det_b);
  assign dot_nxt = 33'(p_dot_a) + 33'(p_dot_b);
  assign dcx_nxt = 33'(bx) - 33'(ax);
  assign dcy_nxt = 33'(by) - 33'(ay);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= acc;
    end
    s1_det_r <= det_nxt;
    s1_dot_r <= dot_nxt;
    s1_dcx_r <= dcx_nxt;
    s1_dcy_r <= dcy_nxt;
    s1_ax_r  <= ax;
    s1_ay_r  <= ay;
    s1_ux_r  <= ux;
    s1_uy_r  <= uy;
    s1_vx_r  <= vx;
    s1_vy_r  <= vy;
  end

  // Stage 2: numerator of the line parameter and the crossing test.
  logic signed [48:0] p_num_a, p_num_b;
  logic signed [49:0] num_nxt;
  logic [31:0]        dot_mag, det_mag_nxt;
  logic               crossing_nxt;

  logic               s2_valid_r;
  logic signed [49:0] s2_num_r;
  logic [31:0]        s2_det_mag_r;
  logic               s2_det_neg_r, s2_found_r, s2_crossing_r;
  logic signed [31:0] s2_ax_r, s2_ay_r;
  logic signed [15:0] s2_ux_r, s2_uy_r;

  assign p_num_a      = s1_dcx_r * s1_vy_r;
  assign p_num_b      = s1_dcy_r * s1_vx_r;
  assign num_nxt      = 50'(p_num_a) - 50'(p_num_b);
  assign dot_mag      = s1_dot_r[32] ? 32'(-s1_dot_r) : 32'(s1_dot_r);
  assign det_mag_nxt  = s1_det_r[32] ? 32'(-s1_det_r) : 32'(s1_det_r);
  assign crossing_nxt = {1'b0, dot_mag} < {4'b0, thr, 14'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
    s2_num_r      <= num_nxt;
    s2_det_mag_r  <= det_mag_nxt;
    s2_det_neg_r  <= s1_det_r[32];
    s2_found_r    <= (s1_det_r != '0);
    s2_crossing_r <= crossing_nxt;
    s2_ax_r       <= s1_ax_r;
    s2_ay_r       <= s1_ay_r;
    s2_ux_r       <= s1_ux_r;
    s2_uy_r       <= s1_uy_r;
  end

  // Stage 3: magnitudes for the divider. The quotient is known to fit in
  // DIV_BITS bits unless the overflow test fires, so the leading remainder is
  // taken straight from the top of the scaled numerator.
  logic [48:0] num_mag;
  logic        ovf;
  lpi_cell_t   cell_nxt, cell_r;

  assign num_mag = s2_num_r[49] ? 49'(-s2_num_r) : 49'(s2_num_r);
  assign ovf     = {17'b0, num_mag} >= {s2_det_mag_r, 34'b0};

  always_comb begin
    cell_nxt               = '0;
    cell_nxt.valid         = s2_valid_r;
    cell_nxt.rem           = {17'b0, num_mag[48:34]};
    cell_nxt.work          = {num_mag[33:0], 14'b0};
    cell_nxt.dvs           = s2_det_mag_r;
    cell_nxt.side.ax       = s2_ax_r;
    cell_nxt.side.ay       = s2_ay_r;
    cell_nxt.side.ux       = s2_ux_r;
    cell_nxt.side.uy       = s2_uy_r;
    cell_nxt.side.t_neg    = s2_num_r[49] ^ s2_det_neg_r;
    cell_nxt.side.ovf      = ovf;
    cell_nxt.side.found    = s2_found_r;
    cell_nxt.side.crossing = s2_crossing_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r <= '0;
    end else begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_o = cell_r;

endmodule

// ===== design/lpi_div_cell.sv =====
// One restoring division step: shifts in a dividend bit and produces one quotient bit.
// Depends on lpi_pkg; instantiated DIV_BITS times in a chain by the top level.
module lpi_div_cell
  import lpi_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  lpi_cell_t cell_i,
  output lpi_cell_t cell_o
);

  logic [REM_W:0] trial, diff;
  logic           ge;
  lpi_cell_t      cell_nxt, cell_r;

  // The work word shifts dividend bits out at the top and quotient bits in
  // at the bottom, so after the last cell it holds the whole quotient.
  always_comb begin
    trial         = {cell_i.rem, cell_i.work[DIV_BITS-1]};
    diff          = trial - {1'b0, cell_i.dvs};
    ge            = trial >= {1'b0, cell_i.dvs};
    cell_nxt      = cell_i;
    cell_nxt.rem  = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
    cell_nxt.work = {cell_i.work[DIV_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r <= '0;
    end else begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_o = cell_r;

endmodule

// ===== design/lpi_back.sv =====
// Back end: rounds and clamps the line parameter, scales the direction, saturates.
// Depends on lpi_pkg; takes the last cell of the divider chain, drives the result ports.
module lpi_back
  import lpi_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  lpi_cell_t          cell_i,
  output logic               out_valid,
  output logic               out_found,
  output logic signed [31:0] out_inter_x,
  output logic signed [31:0] out_inter_y,
  output logic               out_clipped,
  output logic               out_crossing
);

  // Stage A: round to nearest, ties away from zero, then clamp.
  logic [DIV_BITS:0]   q_rnd;
  logic                rnd_up;
  logic [DIV_BITS-1:0] tmag_nxt;

  logic                sa_valid_r;
  logic [DIV_BITS-1:0] sa_tmag_r;
  lpi_side_t           sa_side_r;

  assign rnd_up   = {cell_i.rem, 1'b0} >= {1'b0, cell_i.dvs};
  assign q_rnd    = {1'b0, cell_i.work} + (DIV_BITS+1)'(rnd_up);
  assign tmag_nxt = (cell_i.side.ovf || (q_rnd > {1'b0, T_LIMIT})) ? T_LIMIT
                                                                   : q_rnd[DIV_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_valid_r <= 1'b0;
    end else begin
      sa_valid_r <= cell_i.valid;
    end
    sa_tmag_r <= tmag_nxt;
    sa_side_r <= cell_i.side;
  end

  // Stage B: offset magnitudes along the first direction.
  localparam int PW = DIV_BITS + 16;

  logic [15:0]   ux_mag, uy_mag;
  logic [PW-1:0] px_nxt, py_nxt;

  logic               sb_valid_r;
  logic [PW-1:0]      sb_px_r, sb_py_r;
  logic               sb_neg_x_r, sb_neg_y_r, sb_found_r, sb_crossing_r;
  logic signed [31:0] sb_ax_r, sb_ay_r;

  assign ux_mag = sa_side_r.ux[15] ? 16'(-sa_side_r.ux) : 16'(sa_side_r.ux);
  assign uy_mag = sa_side_r.uy[15] ? 16'(-sa_side_r.uy) : 16'(sa_side_r.uy);
  assign px_nxt = PW'(sa_tmag_r) * PW'(ux_mag);
  assign py_nxt = PW'(sa_tmag_r) * PW'(uy_mag);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_valid_r <= 1'b0;
    end else begin
      sb_valid_r <= sa_valid_r;
    end
    sb_px_r       <= px_nxt;
    sb_py_r       <= py_nxt;
    sb_neg_x_r    <= sa_side_r.t_neg ^ sa_side_r.ux[15];
    sb_neg_y_r    <= sa_side_r.t_neg ^ sa_side_r.uy[15];
    sb_found_r    <= sa_side_r.found;
    sb_crossing_r <= sa_side_r.crossing;
    sb_ax_r       <= sa_side_r.ax;
    sb_ay_r       <= sa_side_r.ay;
  end

  // Stage C: back to Q16.16, add the first point and saturate.
  logic [PW-1:0]      rx_full, ry_full;
  logic [48:0]        ox_mag, oy_mag;
  logic signed [50:0] off_x, off_y, sum_x, sum_y;
  logic               fit_x, fit_y;
  logic signed [31:0] ix_nxt, iy_nxt;

  logic               sc_valid_r, sc_found_r, sc_clipped_r, sc_crossing_r;
  logic signed [31:0] sc_ix_r, sc_iy_r;

  assign rx_full = (sb_px_r + PW'(8192)) >> 14;
  assign ry_full = (sb_py_r + PW'(8192)) >> 14;
  assign ox_mag  = rx_full[48:0];
  assign oy_mag  = ry_full[48:0];
  assign off_x   = sb_neg_x_r ? -$signed({2'b0, ox_mag}) : $signed({2'b0, ox_mag});
  assign off_y   = sb_neg_y_r ? -$signed({2'b0, oy_mag}) : $signed({2'b0, oy_mag});
  assign sum_x   = 51'(sb_ax_r) + off_x;
  assign sum_y   = 51'(sb_ay_r) + off_y;
  assign fit_x   = (&sum_x[50:31]) || !(|sum_x[50:31]);
  assign fit_y   = (&sum_y[50:31]) || !(|sum_y[50:31]);

  always_comb begin
    if (!sb_found_r) begin
      ix_nxt = '0;
    end else if (fit_x) begin
      ix_nxt = sum_x[31:0];
    end else begin
      ix_nxt = sum_x[50] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    if (!sb_found_r) begin
      iy_nxt = '0;
    end else if (fit_y) begin
      iy_nxt = sum_y[31:0];
    end else begin
      iy_nxt = sum_y[50] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_valid_r <= 1'b0;
    end else begin
      sc_valid_r <= sb_valid_r;
    end
    sc_found_r    <= sb_found_r;
    sc_ix_r       <= ix_nxt;
    sc_iy_r       <= iy_nxt;
    sc_clipped_r  <= sb_found_r && !(fit_x && fit_y);
    sc_crossing_r <= sb_crossing_r;
  end

  assign out_valid    = sc_valid_r;
  assign out_found    = sc_found_r;
  assign out_inter_x  = sc_ix_r;
  assign out_inter_y  = sc_iy_r;
  assign out_clipped  = sc_clipped_r;
  assign out_crossing = sc_crossing_r;

endmodule

// ===== design/lpi_checker.sv =====
// Port-level checks for line_pair_intersection_core and the bind that attaches them.
// Depends on lpi_pkg for the pipeline latency.
module lpi_checker
  import lpi_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic signed [31:0] in_first_point_x,
  input logic signed [31:0] in_first_point_y,
  input logic signed [15:0] in_first_dir_x,
  input logic signed [15:0] in_first_dir_y,
  input logic signed [31:0] in_second_point_x,
  input logic signed [31:0] in_second_point_y,
  input logic signed [15:0] in_second_dir_x,
  input logic signed [15:0] in_second_dir_y,
  input logic               cfg_we,
  input logic [14:0]        cfg_wdata,
  input logic               out_valid,
  input logic               out_found,
  input logic signed [31:0] out_inter_x,
  input logic signed [31:0] out_inter_y,
  input logic               out_clipped,
  input logic               out_crossing
);

  // Once out of reset the block takes a request every cycle.
  a_ready_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy high after reset");

  // Every accepted request yields its result at the fixed latency.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("result missing for an accepted request");

  // No result appears without a request at the matching distance.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without a request");

  // Parallel lines give a zero point and no saturation.
  a_parallel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_inter_x == 0 && out_inter_y == 0 && !out_clipped))
    else $error("nonzero payload on a parallel pair");

  // Saturation can only be reported for an intersection that was found.
  a_clip_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_clipped) |-> out_found)
    else $error("clipped without an intersection");

endmodule

bind line_pair_intersection_core lpi_checker u_lpi_checker (.*);
